### rtl/bol_pkg.sv
// bol_pkg: shared types and constants for the bounded ordered list unit
// operation and status codes, sequencer states, fixed field widths
// no dependencies
package bol_pkg;

	// fixed payload widths
	localparam int VALUE_W = 32;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	// operation requested by one transaction
	typedef enum logic [1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_ROTATE = 2'd2,
		FUNC_SEARCH = 2'd3
	} func_t;

	// result status
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_ROTATE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

endpackage

### rtl/bol_req_if.sv
// bol_req_if: request channel of the bounded ordered list unit
// carries valid, ready, the operation and its operand
// depends on bol_pkg
interface bol_req_if;
	import bol_pkg::*;

	logic                      valid;
	logic                      ready;
	func_t                     func;
	logic signed [VALUE_W-1:0] value;

	modport source(output valid, output func, output value, input ready);
	modport sink(input valid, input func, input value, output ready);

endinterface

### rtl/bol_rsp_if.sv
// bol_rsp_if: response channel of the bounded ordered list unit
// carries valid, ready, status, matched position, count and flags
// depends on bol_pkg
interface bol_rsp_if;
	import bol_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic [POS_W-1:0]   found_position;
	logic [COUNT_W-1:0] entry_count;
	logic               is_full;
	logic               is_empty;

	modport source(output valid, output status, output found_position, output entry_count,
		output is_full, output is_empty, input ready);
	modport sink(input valid, input status, input found_position, input entry_count,
		input is_full, input is_empty, output ready);

endinterface

### rtl/bounded_ordered_list_unit.sv
// bounded_ordered_list_unit: ordered list of up to DEPTH signed values
// ring buffer in bol_ram walked by a small sequencer with one comparator
// depends on bol_pkg, bol_req_if, bol_rsp_if, bol_ram
//
//  channel | direction | payload                                         | handshake
//  req     | in        | func, value                                     | valid/ready
//  rsp     | out       | status, found_position, entry_count, is_full,   | valid/ready
//          |           | is_empty                                        |
//
// append writes in S_DECODE; rotate moves the tail entry to just before the head
// search and remove walk the entries through the single RAM read port, one per cycle
// reset clears count, head and the sequencer; the entry RAM needs no clearing
// req is ready only while the sequencer is idle; a held result does not block the next request
// a stalled rsp holds the sequencer in its final state until the output register frees
module bounded_ordered_list_unit #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	bol_req_if.sink   req,
	bol_rsp_if.source rsp
);
	import bol_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam logic [IDX_W:0]   SPAN = (IDX_W + 1)'(DEPTH);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

	// ring address of logical offset off from base
	function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= SPAN) begin
			sum = sum - SPAN;
		end
		return sum[IDX_W-1:0];
	endfunction

	state_t             state_q, state_d;
	func_t              func_q;
	logic [VALUE_W-1:0] value_q;
	logic [IDX_W-1:0]   head_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      issue_q;
	logic               cmp_vld_q;
	logic [IDX_W-1:0]   cmp_idx_q;
	logic [IDX_W-1:0]   pos_q;
	status_t            status_q;

	logic               rsp_vld_q;
	status_t            rsp_status_q;
	logic [POS_W-1:0]   rsp_pos_q;
	logic [COUNT_W-1:0] rsp_cnt_q;
	logic               rsp_full_q;
	logic               rsp_empty_q;

	logic               ram_we, ram_re;
	logic [IDX_W-1:0]   ram_waddr, ram_raddr;
	logic [VALUE_W-1:0] ram_wdata, rd_data;

	logic             cnt_full, cnt_zero, cnt_small;
	logic             issue_ok, issue_go, rd_hit, scan_done, rsp_free;
	logic [CW-1:0]    cnt_m1;
	logic [IDX_W-1:0] tail_addr, head_m1;

	// entry storage
	bol_ram #(
		.DEPTH(DEPTH),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// status of count, walk pointer and comparator
	always_comb begin
		cnt_full  = (count_q == CW'(DEPTH));
		cnt_zero  = (count_q == '0);
		cnt_small = (count_q < CW'(2));
		cnt_m1    = count_q - CW'(1);
		tail_addr = phys_addr(head_q, cnt_m1[IDX_W-1:0]);
		head_m1   = (head_q == '0) ? LAST : head_q - IDX_W'(1);
		issue_ok  = (issue_q < count_q);
		rd_hit    = cmp_vld_q && (rd_data == value_q);
		scan_done = !issue_ok && !cmp_vld_q;
		rsp_free  = !rsp_vld_q || rsp.ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (func_q)
					FUNC_APPEND: state_d = S_FINISH;
					FUNC_ROTATE: state_d = cnt_small ? S_FINISH : S_ROTATE;
					default:     state_d = cnt_zero ? S_FINISH : S_SCAN;
				endcase
			end
			S_ROTATE: state_d = S_FINISH;
			S_SCAN: begin
				if (rd_hit) begin
					state_d = (func_q == FUNC_REMOVE) ? S_SHIFT : S_FINISH;
				end else if (scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_SHIFT: begin
				if (scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ram control and handshake outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = value_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		issue_go  = 1'b0;
		case (state_q)
			S_DECODE: begin
				if (func_q == FUNC_APPEND && !cnt_full) begin
					ram_we    = 1'b1;
					ram_waddr = phys_addr(head_q, count_q[IDX_W-1:0]);
				end
				if (func_q == FUNC_ROTATE) begin
					ram_re    = 1'b1;
					ram_raddr = tail_addr;
				end
			end
			S_ROTATE: begin
				ram_we    = 1'b1;
				ram_waddr = head_m1;
				ram_wdata = rd_data;
			end
			S_SCAN: begin
				issue_go  = issue_ok;
				ram_re    = issue_ok;
				ram_raddr = phys_addr(head_q, issue_q[IDX_W-1:0]);
			end
			S_SHIFT: begin
				issue_go  = issue_ok;
				ram_re    = issue_ok;
				ram_raddr = phys_addr(head_q, issue_q[IDX_W-1:0]);
				ram_we    = cmp_vld_q;
				ram_waddr = phys_addr(head_q, cmp_idx_q - IDX_W'(1));
				ram_wdata = rd_data;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			head_q    <= '0;
			issue_q   <= '0;
			cmp_vld_q <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_DECODE: begin
					issue_q   <= '0;
					cmp_vld_q <= 1'b0;
					if (func_q == FUNC_APPEND && !cnt_full) begin
						count_q <= count_q + CW'(1);
					end
				end
				S_ROTATE: head_q <= head_m1;
				S_SCAN: begin
					if (issue_go) begin
						issue_q <= issue_q + CW'(1);
					end
					cmp_vld_q <= issue_go;
				end
				S_SHIFT: begin
					if (issue_go) begin
						issue_q <= issue_q + CW'(1);
					end
					cmp_vld_q <= issue_go;
					if (scan_done) begin
						count_q <= cnt_m1;
					end
				end
				default: begin
					cmp_vld_q <= 1'b0;
				end
			endcase
			if (state_q == S_FINISH && rsp_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q  <= req.func;
			value_q <= req.value;
		end
		if (ram_re) begin
			cmp_idx_q <= issue_q[IDX_W-1:0];
		end
		case (state_q)
			S_DECODE: begin
				pos_q <= '0;
				case (func_q)
					FUNC_APPEND: status_q <= cnt_full ? ST_FULL : ST_DONE;
					FUNC_REMOVE: status_q <= cnt_zero ? ST_EMPTY : ST_DONE;
					FUNC_SEARCH: status_q <= cnt_zero ? ST_NOT_FOUND : ST_DONE;
					default:     status_q <= ST_DONE;
				endcase
			end
			S_SCAN: begin
				if (rd_hit) begin
					pos_q <= cmp_idx_q;
				end else if (scan_done) begin
					status_q <= ST_NOT_FOUND;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
		if (state_q == S_FINISH && rsp_free) begin
			rsp_status_q <= status_q;
			rsp_pos_q    <= POS_W'(pos_q);
			rsp_cnt_q    <= COUNT_W'(count_q);
			rsp_full_q   <= cnt_full;
			rsp_empty_q  <= cnt_zero;
		end
	end

	// response outputs
	assign rsp.valid          = rsp_vld_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.found_position = rsp_pos_q;
	assign rsp.entry_count    = rsp_cnt_q;
	assign rsp.is_full        = rsp_full_q;
	assign rsp.is_empty       = rsp_empty_q;

`ifndef SYNTHESIS
	// count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above capacity");

	// a refused append reports a full list
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_status_q == ST_FULL |-> rsp_full_q)
		else $error("full status without full flag");

	// a refused remove reports an empty list
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_status_q == ST_EMPTY |-> rsp_empty_q)
		else $error("empty status without empty flag");

	// a position is only reported on a match
	a_pos_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_pos_q != '0 |-> rsp_status_q == ST_DONE)
		else $error("position reported without match");

	// compaction only runs on a nonempty list
	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> !cnt_zero)
		else $error("compaction on empty list");
`endif

endmodule

### rtl/bol_ram.sv
// bol_ram: entry storage, one write port and one registered read port
// holds the list values in ring order
// depends on bol_pkg
module bol_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [bol_pkg::VALUE_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [bol_pkg::VALUE_W-1:0] rdata
);
	import bol_pkg::*;

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### tb/sv/testbench.sv
// testbench: self-checking regression for bounded_ordered_list_unit
// random request and response stalls, scoreboard class tracks the list contents
// depends on bol_pkg, bol_req_if, bol_rsp_if and the unit itself
module testbench;
	import bol_pkg::*;

	localparam int LIST_DEPTH  = 16;
	localparam int PHASES      = 14;
	localparam int PHASE_ITEMS = 125;
	localparam int POOL_SIZE   = 6;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 40;

	// stimulus mixes of the random phases
	localparam int MIX_FILL     = 0;
	localparam int MIX_BALANCED = 1;
	localparam int MIX_DRAIN    = 2;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	// mirror of the list contents and the queue of replies it predicts
	class list_scoreboard;
		typedef struct {
			status_t            status;
			logic [POS_W-1:0]   pos;
			logic [COUNT_W-1:0] count;
			logic               full;
			logic               empty;
		} reply_t;

		logic signed [VALUE_W-1:0] entries [LIST_DEPTH];
		int unsigned               fill;
		reply_t                    pending_replies [$];
		int unsigned               failures;

		function new();
			fill = 0;
			failures = 0;
		endfunction

		function int unsigned outstanding();
			return pending_replies.size();
		endfunction

		function logic signed [VALUE_W-1:0] entry_at(int unsigned idx);
			return entries[idx];
		endfunction

		// index of the first entry equal to v, or fill when absent
		function int unsigned locate(logic signed [VALUE_W-1:0] v);
			for (int unsigned i = 0; i < fill; i++) begin
				if (entries[i] == v)
					return i;
			end
			return fill;
		endfunction

		// apply one accepted request to the mirror and queue its reply
		function void note_request(func_t op, logic signed [VALUE_W-1:0] v);
			reply_t                    r;
			int unsigned               idx;
			logic signed [VALUE_W-1:0] last;
			r.status = ST_DONE;
			r.pos = '0;
			case (op)
				FUNC_APPEND: begin
					if (fill >= LIST_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						entries[fill] = v;
						fill++;
					end
				end
				FUNC_REMOVE: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else begin
						idx = locate(v);
						if (idx >= fill) begin
							r.status = ST_NOT_FOUND;
						end else begin
							r.pos = idx[POS_W-1:0];
							for (int unsigned i = idx; i + 1 < fill; i++)
								entries[i] = entries[i+1];
							fill--;
						end
					end
				end
				FUNC_ROTATE: begin
					if (fill >= 2) begin
						last = entries[fill-1];
						for (int unsigned i = fill - 1; i > 0; i--)
							entries[i] = entries[i-1];
						entries[0] = last;
					end
				end
				default: begin
					idx = locate(v);
					if (idx >= fill)
						r.status = ST_NOT_FOUND;
					else
						r.pos = idx[POS_W-1:0];
				end
			endcase
			r.count = fill[COUNT_W-1:0];
			r.full = (fill == LIST_DEPTH);
			r.empty = (fill == 0);
			pending_replies.push_back(r);
		endfunction

		// compare one accepted reply with the oldest prediction
		function void check_reply(status_t st, logic [POS_W-1:0] pos,
				logic [COUNT_W-1:0] cnt, logic full, logic empty);
			reply_t e;
			if (pending_replies.size() == 0) begin
				$error("unexpected reply: status %0d count %0d", st, cnt);
				failures++;
				return;
			end
			e = pending_replies.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				failures++;
			end
			if (pos !== e.pos) begin
				$error("found_position: expected %0d, actual %0d", e.pos, pos);
				failures++;
			end
			if (cnt !== e.count) begin
				$error("entry_count: expected %0d, actual %0d", e.count, cnt);
				failures++;
			end
			if (full !== e.full) begin
				$error("is_full: expected %0d, actual %0d", e.full, full);
				failures++;
			end
			if (empty !== e.empty) begin
				$error("is_empty: expected %0d, actual %0d", e.empty, empty);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bol_req_if req_ch ();
	bol_rsp_if rsp_ch ();

	bounded_ordered_list_unit #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	list_scoreboard tracker;

	logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];
	bit                        req_quiet = 1'b0;
	bit                        rsp_quiet = 1'b0;
	int unsigned               cycle_count = 0;

	// clock
	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bounded_ordered_list_unit regression: fail");
			$finish;
		end
	end

	// gap length: mostly none or short, now and then long
	function automatic int unsigned pick_gap(bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// operation drawn according to the phase mix
	function automatic func_t pick_func(int mix);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				if (r < 75) return FUNC_APPEND;
				if (r < 80) return FUNC_REMOVE;
				if (r < 90) return FUNC_ROTATE;
				return FUNC_SEARCH;
			end
			MIX_DRAIN: begin
				if (r < 10) return FUNC_APPEND;
				if (r < 70) return FUNC_REMOVE;
				if (r < 80) return FUNC_ROTATE;
				return FUNC_SEARCH;
			end
			default: begin
				if (r < 30) return FUNC_APPEND;
				if (r < 55) return FUNC_REMOVE;
				if (r < 70) return FUNC_ROTATE;
				return FUNC_SEARCH;
			end
		endcase
	endfunction

	// operand: often a value held in the list, else pool, random or extreme
	function automatic logic signed [VALUE_W-1:0] pick_value(bit prefer_held);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (prefer_held && tracker.fill > 0 && r < 60)
			return tracker.entry_at($urandom_range(0, tracker.fill - 1));
		if (r < 75)
			return value_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 88)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return -1;
			default: return 0;
		endcase
	endfunction

	// new set of operand values; one value is usually duplicated, extremes appear now and then
	task automatic refresh_pool();
		for (int i = 0; i < POOL_SIZE; i++)
			value_pool[i] = ($urandom_range(0, 9) == 0) ? VAL_MIN : $urandom;
		value_pool[$urandom_range(0, POOL_SIZE - 1)] = value_pool[0];
	endtask

	// one request transaction, preceded by a random gap
	task automatic send_request(func_t op, logic signed [VALUE_W-1:0] v);
		int unsigned gap;
		gap = pick_gap(req_quiet);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= op;
		req_ch.value <= v;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		tracker.note_request(op, v);
	endtask

	// hold requests back until every predicted reply has arrived
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() != 0);
	endtask

	// response ready with random stalls
	initial begin
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = pick_gap(rsp_quiet);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			tracker.check_reply(rsp_ch.status, rsp_ch.found_position, rsp_ch.entry_count,
				rsp_ch.is_full, rsp_ch.is_empty);
	end

	// main sequence
	initial begin
		int mix;
		func_t op;
		tracker = new();
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.func <= FUNC_APPEND;
		req_ch.value <= '0;
		refresh_pool();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list cases
		send_request(FUNC_SEARCH, 0);
		send_request(FUNC_REMOVE, 0);
		send_request(FUNC_ROTATE, 0);
		// single entry: rotate does nothing, removing it empties the list
		send_request(FUNC_APPEND, VAL_MIN);
		send_request(FUNC_ROTATE, -1);
		send_request(FUNC_SEARCH, VAL_MIN);
		send_request(FUNC_REMOVE, VAL_MIN);
		// several entries, extremes of the operand
		send_request(FUNC_APPEND, VAL_MAX);
		send_request(FUNC_APPEND, -1);
		send_request(FUNC_APPEND, 0);
		send_request(FUNC_SEARCH, VAL_MAX);
		send_request(FUNC_SEARCH, 12345);
		send_request(FUNC_REMOVE, 12345);
		// remove the tail, then append to see the tail follow
		send_request(FUNC_REMOVE, 0);
		send_request(FUNC_APPEND, 1);
		send_request(FUNC_SEARCH, 1);
		send_request(FUNC_ROTATE, 0);
		send_request(FUNC_REMOVE, -1);
		send_request(FUNC_SEARCH, VAL_MAX);
		wait_drained();

		// random phases: fill to full, mixed traffic, drain to empty
		for (int phase = 0; phase < PHASES; phase++) begin
			mix = phase % 3;
			req_quiet = (phase % 4 == 1) || (phase % 5 == 3);
			rsp_quiet = (phase % 4 == 2) || (phase % 5 == 3);
			refresh_pool();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = pick_func(mix);
				send_request(op, pick_value(op != FUNC_APPEND));
			end
			if (phase == PHASES / 2)
				wait_drained();
		end
		req_ch.valid <= 1'b0;

		// let every reply arrive, then watch for strays
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (tracker.failures == 0 && tracker.outstanding() == 0)
			$display("bounded_ordered_list_unit regression: pass");
		else
			$display("bounded_ordered_list_unit regression: fail");
		$finish;
	end

endmodule
